// File: rtl/core/pru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
package pru_pkg;

    localparam int unsigned SCALE_W   = 7;
    localparam int unsigned RWIDTH_W  = 12;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned PIX_W     = 24;
    localparam int unsigned SCALE_MAX = 100;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_WIDTH = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       group_end;
    } t_out_item;

    // Flags of one emit transaction travelling beside the line buffer read.
    typedef struct packed {
        logic       valid;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       group_end;
    } t_emit_ctl;

endpackage

// File: rtl/core/pixel_replication_upscaler.sv
// An accepted emit transaction passes through the read stage and then the output register
// before its pixel can be accepted downstream.
// Throughput: one transaction per cycle, load or emit, while the output side is not stalled.
// The line buffer's registered read and the output register are the two stages of an emit.
// Reset is synchronous and active low; it clears counters and valid flags and sets scale and width to 1.
// The line buffer has no reset: entries are written by loads before any emit reads them.
module pixel_replication_upscaler #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [pru_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pru_pkg::t_in_item         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pru_pkg::t_out_item        o_out
);
    import pru_pkg::*;

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic             take;
    logic             load_en;
    logic             rd_pending;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [PIX_W-1:0] ram_rdata;
    t_emit_ctl        info;

    // The read stage can take a new transaction whenever it is empty or is
    // moving into the output register in this cycle, so a full output that
    // is stalled still lets one more transaction in.
    assign o_in_stall = !load_en;
    assign take       = i_in_valid && load_en;

    // Counters and configuration. Loads write the pixel at the fill count;
    // emits read the current column and update the copy, column and row
    // replay counters in the same cycle.
    pru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_item     (i_in),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .o_info     (info)
    );

    // One input row of pixels. A read is issued only when an emit enters the
    // read stage, so the registered data holds while that stage is stalled.
    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read stage and output register.
    pru_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_info       (info),
        .i_rdata      (ram_rdata),
        .i_out_stall  (i_out_stall),
        .o_load_en    (load_en),
        .o_rd_pending (rd_pending),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

    // A group ends only on the last pixel of a row.
    a_group_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.group_end) |-> o_out.row_end)
        else $error("group_end without row_end");

    // Padding is reported only at the end of a row.
    a_pad_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.row_end) |-> (o_out.pad_bytes == 2'd0))
        else $error("pad_bytes set away from row end");

    // Input is held back only when both the read stage and output are full.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && rd_pending))
        else $error("input stalled with free pipeline space");

    // A drained output with nothing in the read stage goes empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !rd_pending) |=> !o_out_valid)
        else $error("output transaction repeated");

endmodule

// File: rtl/core/pru_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pru_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pru_ctrl.sv
// Configuration registers, fill and replay counters, and line buffer addressing.
module pru_ctrl #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_we,
    input  logic                                              i_cfg_idx,
    input  logic [pru_pkg::CFG_W-1:0]                         i_cfg_data,
    input  logic                                              i_take,
    input  pru_pkg::t_in_item                                 i_item,
    output logic                                              o_we,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_waddr,
    output logic [pru_pkg::PIX_W-1:0]                         o_wdata,
    output logic                                              o_re,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_raddr,
    output pru_pkg::t_emit_ctl                                o_info
);
    import pru_pkg::*;

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned FW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WW = (FW > RWIDTH_W) ? FW : RWIDTH_W;

    logic [SCALE_W-1:0]  r_scale;
    logic [RWIDTH_W-1:0] r_width;
    logic [FW-1:0]       r_fill,  n_fill;
    logic [AW-1:0]       r_col,   n_col;
    logic [SCALE_W-1:0]  r_copy,  n_copy;
    logic [SCALE_W-1:0]  r_rep,   n_rep;

    logic [SCALE_W-1:0]  s_eff;
    logic [WW-1:0]       w_eff;
    logic                row_full;
    logic                last_copy;
    logic                last_col;
    logic                last_rep;
    logic                do_load;
    logic                do_emit;
    logic                row_end;
    logic [3:0]          pad_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= RWIDTH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_WIDTH: r_width <= i_cfg_data[RWIDTH_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    always_comb begin
        if (r_scale == '0) begin
            s_eff = SCALE_W'(1);
        end else if (r_scale > SCALE_W'(SCALE_MAX)) begin
            s_eff = SCALE_W'(SCALE_MAX);
        end else begin
            s_eff = r_scale;
        end

        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
    end

    assign row_full  = WW'(r_fill) >= w_eff;
    assign last_copy = ({1'b0, r_copy} + 1'b1) >= {1'b0, s_eff};
    assign last_rep  = ({1'b0, r_rep} + 1'b1) >= {1'b0, s_eff};
    assign last_col  = ((WW+1)'(r_col) + 1'b1) >= {1'b0, w_eff};
    assign row_end   = last_copy && last_col;

    assign do_load = i_take && (i_item.opcode == OP_LOAD) && !row_full;
    assign do_emit = i_take && (i_item.opcode == OP_EMIT) && row_full;

    // Only the low two bits of width and scale decide the product mod 4.
    assign pad_prod = w_eff[1:0] * s_eff[1:0];

    always_comb begin
        n_fill = r_fill;
        n_col  = r_col;
        n_copy = r_copy;
        n_rep  = r_rep;
        if (do_load) begin
            n_fill = r_fill + 1'b1;
        end
        if (do_emit) begin
            if (!last_copy) begin
                n_copy = r_copy + 1'b1;
            end else begin
                n_copy = '0;
                n_col  = last_col ? '0 : r_col + 1'b1;
            end
            if (row_end) begin
                if (last_rep) begin
                    n_rep  = '0;
                    n_fill = '0;
                end else begin
                    n_rep = r_rep + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_col  <= '0;
            r_copy <= '0;
            r_rep  <= '0;
        end else begin
            r_fill <= n_fill;
            r_col  <= n_col;
            r_copy <= n_copy;
            r_rep  <= n_rep;
        end
    end

    assign o_we    = do_load;
    assign o_waddr = r_fill[AW-1:0];
    assign o_wdata = {i_item.red_in, i_item.green_in, i_item.blue_in};
    assign o_re    = do_emit;
    assign o_raddr = r_col;

    assign o_info.valid     = do_emit;
    assign o_info.row_end   = row_end;
    assign o_info.pad_bytes = row_end ? pad_prod[1:0] : 2'd0;
    assign o_info.group_end = row_end && last_rep;

endmodule

// File: rtl/core/pru_out.sv
// Read stage and output register that join line buffer data with emit flags.
module pru_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pru_pkg::t_emit_ctl            i_info,
    input  logic [pru_pkg::PIX_W-1:0]     i_rdata,
    input  logic                          i_out_stall,
    output logic                          o_load_en,
    output logic                          o_rd_pending,
    output logic                          o_out_valid,
    output pru_pkg::t_out_item            o_out
);
    import pru_pkg::*;

    t_emit_ctl r_rd;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;

    assign advance   = !r_out_valid || !i_out_stall;
    assign o_load_en = advance || !r_rd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_rd.valid;
            end
            if (o_load_en) begin
                r_rd <= i_info;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_rd.valid) begin
            r_out.blue_out  <= i_rdata[7:0];
            r_out.green_out <= i_rdata[15:8];
            r_out.red_out   <= i_rdata[23:16];
            r_out.row_end   <= r_rd.row_end;
            r_out.pad_bytes <= r_rd.pad_bytes;
            r_out.group_end <= r_rd.group_end;
        end
    end

    assign o_rd_pending = r_rd.valid;
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;

endmodule
